[rtl/core/adc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adc_pkg
// Shared types and constants for the approximate double compare.
// ----------------------------------------------------------------------------
package adc_pkg;

    localparam int EXP_W  = 11;
    localparam int FRAC_W = 52;
    localparam int MANT_W = FRAC_W + 1;   // with hidden bit
    localparam int DIFF_W = MANT_W + 1;   // aligned difference, shift of at most one
    localparam int LEAD_W = 6;            // index into the difference
    localparam int EDIF_W = EXP_W + 2;    // exponent sums with headroom

    localparam logic [EXP_W-1:0] EXP_MAX = '1;

    typedef enum logic [2:0] {
        FN_EQUALS = 3'd0,
        FN_COMPARE = 3'd1,
        FN_GREATER = 3'd2,
        FN_GREATER_EQ = 3'd3,
        FN_LESS = 3'd4,
        FN_LESS_EQ = 3'd5
    } func_t;

    typedef logic signed [1:0] order_t;
    localparam order_t ORD_EQ = 2'sd0;
    localparam order_t ORD_GT = 2'sd1;
    localparam order_t ORD_LT = -2'sd1;

    // per-item flags carried down the pipeline
    typedef struct packed {
        logic [2:0]       func;
        logic             nan;
        logic             exact_eq;
        logic             gt_raw;
        logic             cand;
        logic [EXP_W-1:0] exp_l;
        logic [EXP_W-1:0] exp_r;
    } item_t;

endpackage
`default_nettype wire

[rtl/core/approx_double_compare.sv]
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one request per cycle; the four-stage pipeline advances as a whole
// whenever its output register is empty or being taken.
// Reset: synchronous active-low aresetn empties the pipeline and sets
// exponent_gap to 48.
// ----------------------------------------------------------------------------
// approx_double_compare
// Compares two double bit patterns, treating them as equal when exactly equal
// or when the exponent of their difference lies more than exponent_gap below
// both operand exponents; returns a three-way order and a predicate answer.
// ----------------------------------------------------------------------------
module approx_double_compare #(
    parameter int GAP_RESET = 48
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire  [127:0]                       s_tdata,   // [63:0] left_bits, [127:64] right_bits
    input  wire  [2:0]                         s_tuser,   // [2:0] func
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [7:0]                         m_tdata,   // [1:0] order, [2] answer, zero fill
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [adc_pkg::EXP_W-1:0]          cfg_data   // exponent_gap
);
    import adc_pkg::*;

    logic             advance;
    logic [EXP_W-1:0] gap_reg;

    logic             v1_reg, v2_reg, v3_reg, v4_reg;
    item_t            it1_reg, it2_reg, it3_reg;
    item_t            it1_next;
    logic [MANT_W-1:0] big1_reg, small1_reg, big1_next, small1_next;
    logic             k1_reg, k1_next;
    logic [EXP_W-1:0] emin1_reg, emin2_reg, emin1_next;
    logic [DIFF_W-1:0] d2_reg, d2_next;
    logic [EXP_W-1:0] ed3_reg, ed3_next;
    order_t           order4_reg, order4_next;
    logic             ans4_reg, ans4_next;
    logic [2:0]       func4_reg;

    assign advance   = !v4_reg || m_tready;
    assign s_tready  = advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = v4_reg;
    assign m_tdata   = {5'd0, ans4_reg, order4_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_reg <= EXP_W'(GAP_RESET);
        end else if (cfg_valid) begin
            gap_reg <= cfg_data;
        end
    end

    // stage 1: classify, magnitude compare, order operands by size
    always_comb begin
        logic [63:0]       lb, rb;
        logic [EXP_W-1:0]  el, er, eal, ear, ebig, esmall, kd;
        logic [MANT_W-1:0] ml, mr;
        logic              nan_l, nan_r, zero_both, mag_gt, mag_ge, fin;
        lb = s_tdata[63:0];
        rb = s_tdata[127:64];
        el = lb[62:52];
        er = rb[62:52];
        nan_l = (el == EXP_MAX) && (lb[51:0] != '0);
        nan_r = (er == EXP_MAX) && (rb[51:0] != '0);
        zero_both = (lb[62:0] == '0) && (rb[62:0] == '0);
        mag_gt = lb[62:0] > rb[62:0];
        mag_ge = lb[62:0] >= rb[62:0];
        fin = (el != EXP_MAX) && (er != EXP_MAX);
        ml = {(el != '0), lb[51:0]};
        mr = {(er != '0), rb[51:0]};
        // subnormals scale like exponent one
        eal = (el == '0) ? EXP_W'(1) : el;
        ear = (er == '0) ? EXP_W'(1) : er;
        big1_next   = mag_ge ? ml : mr;
        small1_next = mag_ge ? mr : ml;
        ebig        = mag_ge ? eal : ear;
        esmall      = mag_ge ? ear : eal;
        kd          = ebig - esmall;
        k1_next     = kd[0];
        emin1_next  = esmall;
        it1_next.func     = s_tuser;
        it1_next.nan      = nan_l || nan_r;
        it1_next.exact_eq = !(nan_l || nan_r) && ((lb == rb) || zero_both);
        if (lb[63] != rb[63]) begin
            it1_next.gt_raw = !lb[63];
        end else begin
            it1_next.gt_raw = lb[63] ? (rb[62:0] > lb[62:0]) : mag_gt;
        end
        // only a same-sign pair with exponents at most one apart can come out near
        it1_next.cand  = fin && (lb[63] == rb[63]) && (kd <= EXP_W'(1));
        it1_next.exp_l = el;
        it1_next.exp_r = er;
    end

    // stage 2: exact aligned difference
    assign d2_next = ({1'b0, big1_reg} << k1_reg) - {1'b0, small1_reg};

    // stage 3: exponent of the difference from its leading one
    always_comb begin
        logic [LEAD_W-1:0]     lead;
        logic signed [EDIF_W-1:0] e;
        lead = '0;
        for (int i = 0; i < DIFF_W; i++) begin
            if (d2_reg[i]) begin
                lead = LEAD_W'(i);
            end
        end
        e = $signed({2'b00, emin2_reg}) + $signed({{(EDIF_W-LEAD_W){1'b0}}, lead})
            - EDIF_W'(FRAC_W);
        ed3_next = (e <= 0) ? '0 : e[EXP_W-1:0];
    end

    // stage 4: tolerance test and predicate
    always_comb begin
        logic [EDIF_W-1:0] lim;
        logic near, eq, gt, lt;
        lim  = {2'b00, ed3_reg} + {2'b00, gap_reg};
        near = it3_reg.cand && (lim < {2'b00, it3_reg.exp_l})
               && (lim < {2'b00, it3_reg.exp_r});
        eq   = !it3_reg.nan && (it3_reg.exact_eq || near);
        gt   = !it3_reg.nan && !eq && it3_reg.gt_raw;
        lt   = !it3_reg.nan && !eq && !it3_reg.gt_raw;
        order4_next = eq ? ORD_EQ : (gt ? ORD_GT : ORD_LT);
        case (it3_reg.func)
            FN_EQUALS:     ans4_next = eq;
            FN_COMPARE:    ans4_next = eq;
            FN_GREATER:    ans4_next = gt;
            FN_GREATER_EQ: ans4_next = eq || gt;
            FN_LESS:       ans4_next = lt;
            FN_LESS_EQ:    ans4_next = eq || lt;
            default:       ans4_next = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            it1_reg    <= it1_next;
            big1_reg   <= big1_next;
            small1_reg <= small1_next;
            k1_reg     <= k1_next;
            emin1_reg  <= emin1_next;
            it2_reg    <= it1_reg;
            d2_reg     <= d2_next;
            emin2_reg  <= emin1_reg;
            it3_reg    <= it2_reg;
            ed3_reg    <= ed3_next;
            order4_reg <= order4_next;
            ans4_reg   <= ans4_next;
            func4_reg  <= it3_reg.func;
        end
    end

`ifndef SYNTHESIS
    a_order_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] != 2'b10))
        else $error("order code out of range");
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
    a_equals_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (func4_reg == FN_EQUALS || func4_reg == FN_COMPARE))
        |-> (m_tdata[2] == (m_tdata[1:0] == 2'b00)))
        else $error("equals answer disagrees with order");
    a_nan_never_eq: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && advance && it3_reg.nan) |=> (m_tdata[1:0] == 2'b11))
        else $error("nan operand not ordered below");
`endif

endmodule
`default_nettype wire

[tb/tb_approx_double_compare.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_approx_double_compare
// Self-checking bench for the approximate double compare. Operand pairs and
// predicate selectors go in on the s_ stream. The expected order and answer
// for each pair are worked out with native double arithmetic and held in
// order. Every result taken from the m_ stream is checked against the oldest
// entry. Phases cover directed corner values, several gap settings, random
// idling on both sides, a long output stall and a full drain.
// ----------------------------------------------------------------------------
module tb_approx_double_compare;
    import adc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [7:0]   m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [EXP_W-1:0] cfg_data;

    // {answer, order} per request, oldest first
    logic [2:0]   verdict_q[$];
    logic [EXP_W-1:0] gap_setting;
    int           fail_count;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           recv_hold;
    int           quiet_cycles;

    always #4 aclk = ~aclk;

    approx_double_compare dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    function automatic logic [2:0] compare_doubles(logic [2:0] fn, logic [63:0] lb,
                                                   logic [63:0] rb);
        real         l;
        real         r;
        logic [63:0] db;
        int          el;
        int          er;
        int          ed;
        int          g;
        bit          eq;
        bit          gt;
        bit          lt;
        bit          ans;
        order_t      ord;
        l  = $bitstoreal(lb);
        r  = $bitstoreal(rb);
        db = $realtobits(l - r);
        el = int'(lb[62:52]) - 1023;
        er = int'(rb[62:52]) - 1023;
        ed = int'(db[62:52]) - 1023;
        g  = int'(gap_setting);
        eq = (l == r) || ((ed - er < -g) && (ed - el < -g));
        gt = !eq && (l > r);
        lt = !eq && (l < r);
        ord = eq ? ORD_EQ : (gt ? ORD_GT : ORD_LT);
        case (fn)
            FN_EQUALS:     ans = eq;
            FN_COMPARE:    ans = (ord == ORD_EQ);
            FN_GREATER:    ans = gt;
            FN_GREATER_EQ: ans = eq || gt;
            FN_LESS:       ans = lt;
            FN_LESS_EQ:    ans = eq || lt;
            default:       ans = 1'b0;
        endcase
        return {ans, ord};
    endfunction

    task automatic send_pair(logic [2:0] fn, logic [63:0] lb, logic [63:0] rb);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rb, lb};
        s_tuser  <= fn;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        verdict_q.push_back(compare_doubles(fn, lb, rb));
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_gap(logic [EXP_W-1:0] g);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= g;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        gap_setting = g;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] pick_double();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(9))
            0: v[62:52] = '1;                       // inf or nan
            1: v[62:52] = '0;                       // zero or subnormal
            2: v[51:0] = '0;
            default: ;
        endcase
        return v;
    endfunction

    // mostly pairs that sit close together so the gap test is exercised
    task automatic send_random_pair();
        logic [63:0] lb;
        logic [63:0] rb;
        int          k;
        lb = pick_double();
        case ($urandom_range(5))
            0: rb = pick_double();
            1: rb = lb;
            2: rb = {~lb[63], lb[62:0]};
            default: begin
                k  = $urandom_range(52);
                rb = lb ^ ({$urandom, $urandom} & ((64'd1 << k) - 1));
                if ($urandom_range(3) == 0) rb = rb + 64'd1;
            end
        endcase
        if ($urandom_range(1)) send_pair(3'($urandom_range(7)), lb, rb);
        else send_pair(3'($urandom_range(7)), rb, lb);
    endtask

    task automatic test_directed();
        logic [63:0] one;
        one = 64'h3FF0_0000_0000_0000;
        send_pair(FN_EQUALS, 64'h0, 64'h8000_0000_0000_0000);
        send_pair(FN_COMPARE, 64'h7FF0_0000_0000_0000, 64'h7FF0_0000_0000_0000);
        send_pair(FN_GREATER, 64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000);
        send_pair(FN_LESS, 64'hFFF0_0000_0000_0000, 64'h7FEF_FFFF_FFFF_FFFF);
        send_pair(FN_EQUALS, 64'h7FF8_0000_0000_0000, 64'h7FF8_0000_0000_0000);
        send_pair(FN_LESS_EQ, 64'hFFFF_FFFF_FFFF_FFFF, one);
        send_pair(FN_GREATER_EQ, one, 64'h7FF0_0000_0000_0001);
        send_pair(FN_COMPARE, one, one + 64'd1);
        send_pair(FN_EQUALS, one, one + 64'd1);
        send_pair(FN_GREATER, one + 64'd1, one);
        send_pair(FN_LESS, one, 64'h3FF0_0000_0001_0000);
        send_pair(FN_GREATER_EQ, 64'h0000_0000_0000_0001, 64'h0);
        send_pair(FN_LESS_EQ, 64'h0, 64'h0000_0000_0000_0001);
        send_pair(FN_EQUALS, 64'h7FEF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFE);
        send_pair(FN_COMPARE, 64'h7FEF_FFFF_FFFF_FFFF, 64'hFFEF_FFFF_FFFF_FFFF);
        send_pair(3'd6, one, one);
        send_pair(3'd7, 64'h7FF8_0000_0000_0000, one);
        send_pair(FN_GREATER, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_pair(FN_LESS, 64'h8000_0000_0000_0001, 64'h0000_0000_0000_0001);
        send_pair(FN_EQUALS, 64'h0010_0000_0000_0000, 64'h000F_FFFF_FFFF_FFFF);
    endtask

    task automatic test_random(int n, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n) send_random_pair();
    endtask

    task automatic test_gap_sweep();
        logic [EXP_W-1:0] gaps[6];
        gaps = '{11'd1, 11'd2046, 11'd0, 11'd2047, 11'd52, 11'($urandom_range(2047))};
        foreach (gaps[i]) begin
            set_gap(gaps[i]);
            test_directed();
            test_random(40, 30, 30);
        end
        set_gap(11'd48);
    endtask

    // output held off while requests keep coming, so the input stalls
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        recv_hold      = 300;
        repeat (60) send_random_pair();
    endtask

    task automatic test_pause();
        test_random(50, 0, 20);
        drain();
        test_random(50, 0, 20);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        logic [2:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                fail_count++;
            end else begin
                want = verdict_q.pop_front();
                if (m_tdata[1:0] !== want[1:0]) begin
                    $display("%0t: order mismatch, expected %b, actual %b",
                             $time, want[1:0], m_tdata[1:0]);
                    fail_count++;
                end
                if (m_tdata[2] !== want[2]) begin
                    $display("%0t: answer mismatch, expected %b, actual %b",
                             $time, want[2], m_tdata[2]);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aresetn        <= 1'b0;
        s_tvalid       <= 1'b0;
        s_tdata        <= '0;
        s_tuser        <= '0;
        cfg_valid      <= 1'b0;
        cfg_data       <= '0;
        gap_setting    = 11'd48;
        fail_count     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        recv_hold      = 0;
        quiet_cycles   = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random(360, 0, 0);
        test_random(360, 84, 0);
        test_random(360, 0, 84);
        test_random(360, 34, 34);
        test_gap_sweep();
        test_backpressure();
        test_pause();

        drain();
        repeat (12) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
